/* rtl/core/owi_pkg.sv */
// Shared constants, types and helper functions of the omni wheel impulse drive.
package owi_pkg;

	localparam int unsigned PWM_FULL_SCALE_DEF = 255;
	localparam int CORDIC_STEPS = 18;
	localparam int CNT_W = 5;

	localparam int MASS_W = 12;
	localparam logic [MASS_W-1:0] MASS_RESET = 12'd512;

	localparam int MAG_W = 16;
	localparam int ANG_W = 17;
	localparam int DRIVE_W = 9;
	localparam int HEAD_W = 9;
	localparam int SPEED_W = 32;
	localparam int VEL_W = 32;
	localparam int IN_DATA_W = 40;
	localparam int OUT_DATA_W = 72;

	localparam int CX_W = 40;
	localparam int CZ_W = 26;
	localparam int TRIG_W = 32;
	localparam int DIV_NUM_W = 48;
	localparam int DIV_DEN_W = 26;
	localparam int FOLD_W = 19;

	localparam logic signed [CX_W-1:0] GAIN_Q30 = 40'sd652032874;
	localparam logic [31:0] GAIN_Q24 = 32'd10188014;
	localparam logic [7:0] DRIVE_LIMIT = 8'd255;
	localparam logic signed [FOLD_W-1:0] FULL_HD = 19'sd36000;
	localparam logic signed [FOLD_W-1:0] FULL_DEG = 19'sd360;

	localparam logic OP_APPLY = 1'b0;
	localparam logic OP_STOP = 1'b1;

	typedef enum logic [4:0] {
		DP_NONE,
		DP_LOAD,
		DP_ZDIV,
		DP_ROT_INIT,
		DP_ITER,
		DP_TRIG,
		DP_MULX,
		DP_DIVX,
		DP_UPDX,
		DP_MULY,
		DP_DIVY,
		DP_UPDY,
		DP_VPREP,
		DP_SPD1,
		DP_SPD2,
		DP_SPD3,
		DP_WSET,
		DP_WM1,
		DP_WM2,
		DP_WM3,
		DP_WM4,
		DP_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic [CNT_W-1:0] step;
		logic [1:0] wheel;
	} dp_cmd_t;

	typedef struct packed {
		logic stop;
		logic vel_zero;
		logic div_done;
	} dp_stat_t;

	typedef struct packed {
		logic signed [FOLD_W-1:0] r;
		logic flip;
	} fold_t;

	function automatic logic signed [CZ_W-1:0] atan_q16(input logic [CNT_W-1:0] i);
		case (i)
			5'd0: return 26'sd2949120;
			5'd1: return 26'sd1740967;
			5'd2: return 26'sd919879;
			5'd3: return 26'sd466945;
			5'd4: return 26'sd234379;
			5'd5: return 26'sd117304;
			5'd6: return 26'sd58666;
			5'd7: return 26'sd29335;
			5'd8: return 26'sd14668;
			5'd9: return 26'sd7334;
			5'd10: return 26'sd3667;
			5'd11: return 26'sd1833;
			5'd12: return 26'sd917;
			5'd13: return 26'sd458;
			5'd14: return 26'sd229;
			5'd15: return 26'sd115;
			5'd16: return 26'sd57;
			5'd17: return 26'sd29;
			default: return '0;
		endcase
	endfunction

	// Reduces an angle modulo one turn and folds it into the right half plane.
	function automatic fold_t fold_angle(input logic signed [FOLD_W-1:0] v,
			input logic signed [FOLD_W-1:0] full);
		logic signed [FOLD_W-1:0] t;
		logic signed [FOLD_W-1:0] half;
		logic signed [FOLD_W-1:0] quarter;
		fold_t f;
		half = full >>> 1;
		quarter = full >>> 2;
		t = v;
		if (t < 0) t = t + full;
		if (t < 0) t = t + full;
		if (t >= full) t = t - full;
		if (t >= full) t = t - full;
		if (t >= half) t = t - full;
		f.flip = 1'b0;
		if (t > quarter) begin
			t = half - t;
			f.flip = 1'b1;
		end else if (t < -quarter) begin
			t = -half - t;
			f.flip = 1'b1;
		end
		f.r = t;
		return f;
	endfunction

endpackage

/* rtl/core/owi_div.sv */
// Restoring unsigned divider that produces one quotient bit per cycle.
module owi_div import owi_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [DIV_NUM_W-1:0] num,
	input logic [DIV_DEN_W-1:0] den,
	output logic [DIV_NUM_W-1:0] quo,
	output logic done
);

	localparam int DCNT_W = $clog2(DIV_NUM_W);

	logic [DIV_NUM_W-1:0] num_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DCNT_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [DIV_DEN_W:0] trial;
	logic [DIV_DEN_W:0] diff;
	logic fits;

	assign trial = {rem_q, num_q[DIV_NUM_W-1]};
	assign diff = trial - {1'b0, den_q};
	assign fits = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DCNT_W'(DIV_NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
			num_q <= {num_q[DIV_NUM_W-2:0], fits};
		end
	end

	assign quo = num_q;
	assign done = done_q;

endmodule

/* rtl/core/owi_ctrl.sv */
// Controller state machine that sequences the datapath for one item.
module owi_ctrl import owi_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	output logic m_tvalid,
	input logic m_tready,
	input dp_stat_t stat,
	output dp_cmd_t cmd
);

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CHECK,
		ST_ZDIV,
		ST_ZWAIT,
		ST_ROT,
		ST_TRIG,
		ST_MULX,
		ST_DIVX,
		ST_WAITX,
		ST_MULY,
		ST_DIVY,
		ST_WAITY,
		ST_VPREP,
		ST_VEC,
		ST_SPD1,
		ST_SPD2,
		ST_SPD3,
		ST_WSET,
		ST_WROT,
		ST_WM1,
		ST_WM2,
		ST_WM3,
		ST_WM4,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [1:0] wheel_q;
	logic m_tvalid_q;
	logic last_step;
	logic out_free;

	assign last_step = cnt_q == CNT_W'(CORDIC_STEPS - 1);
	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = state_q == ST_IDLE;
	assign m_tvalid = m_tvalid_q;

	always_comb begin
		cmd.step = cnt_q;
		cmd.wheel = wheel_q;
		case (state_q)
			ST_IDLE: cmd.op = s_tvalid ? DP_LOAD : DP_NONE;
			ST_ZDIV: cmd.op = DP_ZDIV;
			ST_ZWAIT: cmd.op = DP_ROT_INIT;
			ST_ROT, ST_VEC, ST_WROT: cmd.op = DP_ITER;
			ST_TRIG: cmd.op = DP_TRIG;
			ST_MULX: cmd.op = DP_MULX;
			ST_DIVX: cmd.op = DP_DIVX;
			ST_WAITX: cmd.op = stat.div_done ? DP_UPDX : DP_NONE;
			ST_MULY: cmd.op = DP_MULY;
			ST_DIVY: cmd.op = DP_DIVY;
			ST_WAITY: cmd.op = stat.div_done ? DP_UPDY : DP_NONE;
			ST_VPREP: cmd.op = DP_VPREP;
			ST_SPD1: cmd.op = DP_SPD1;
			ST_SPD2: cmd.op = DP_SPD2;
			ST_SPD3: cmd.op = DP_SPD3;
			ST_WSET: cmd.op = DP_WSET;
			ST_WM1: cmd.op = DP_WM1;
			ST_WM2: cmd.op = DP_WM2;
			ST_WM3: cmd.op = DP_WM3;
			ST_WM4: cmd.op = DP_WM4;
			ST_FINISH: cmd.op = out_free ? DP_OUT : DP_NONE;
			default: cmd.op = DP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			wheel_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (state_q == ST_FINISH && out_free) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (s_tvalid) state_q <= ST_CHECK;
				ST_CHECK: state_q <= stat.stop ? ST_FINISH : ST_ZDIV;
				ST_ZDIV: state_q <= ST_ZWAIT;
				ST_ZWAIT: begin
					cnt_q <= '0;
					state_q <= ST_ROT;
				end
				ST_ROT: begin
					cnt_q <= cnt_q + 1'b1;
					if (last_step) state_q <= ST_TRIG;
				end
				ST_TRIG: state_q <= ST_MULX;
				ST_MULX: state_q <= ST_DIVX;
				ST_DIVX: state_q <= ST_WAITX;
				ST_WAITX: if (stat.div_done) state_q <= ST_MULY;
				ST_MULY: state_q <= ST_DIVY;
				ST_DIVY: state_q <= ST_WAITY;
				ST_WAITY: if (stat.div_done) state_q <= ST_VPREP;
				ST_VPREP: begin
					cnt_q <= '0;
					wheel_q <= '0;
					state_q <= stat.vel_zero ? ST_WSET : ST_VEC;
				end
				ST_VEC: begin
					cnt_q <= cnt_q + 1'b1;
					if (last_step) state_q <= ST_SPD1;
				end
				ST_SPD1: state_q <= ST_SPD2;
				ST_SPD2: state_q <= ST_SPD3;
				ST_SPD3: state_q <= ST_WSET;
				ST_WSET: begin
					cnt_q <= '0;
					state_q <= ST_WROT;
				end
				ST_WROT: begin
					cnt_q <= cnt_q + 1'b1;
					if (last_step) state_q <= ST_WM1;
				end
				ST_WM1: state_q <= ST_WM2;
				ST_WM2: state_q <= ST_WM3;
				ST_WM3: state_q <= ST_WM4;
				ST_WM4: begin
					if (wheel_q == 2'd2) begin
						state_q <= ST_FINISH;
					end else begin
						wheel_q <= wheel_q + 1'b1;
						state_q <= ST_WSET;
					end
				end
				ST_FINISH: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* rtl/core/owi_dpath.sv */
// Datapath: velocity state, shared CORDIC iteration, multiplier and divider.
module owi_dpath import owi_pkg::*; #(
	parameter int unsigned PWM_FULL_SCALE = PWM_FULL_SCALE_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic [IN_DATA_W-1:0] in_data,
	input logic in_op,
	input logic cfg_wr_en,
	input logic [MASS_W-1:0] cfg_wr_data,
	input dp_cmd_t cmd,
	output dp_stat_t stat,
	output logic [OUT_DATA_W-1:0] out_data
);

	localparam int PWM_W = $clog2(PWM_FULL_SCALE + 1);
	localparam int SC_W = SPEED_W + PWM_W;
	localparam logic signed [CZ_W-1:0] Z90 = 26'sd5898240;
	localparam logic signed [49:0] VEL_MAX50 = 50'sh7FFFFFFF;
	localparam logic signed [49:0] VEL_MIN50 = -50'sh80000000;
	// The quotient by 100 is the product with ceil(2^37 / 100) shifted down by 37.
	localparam logic [31:0] RECIP_100 = 32'd1374389535;
	localparam int RECIP_SH = 37;

	function automatic logic signed [VEL_W-1:0] sat_add(input logic signed [VEL_W-1:0] v,
			input logic [DIV_NUM_W-1:0] q, input logic neg);
		logic signed [49:0] e;
		logic signed [49:0] qe;
		logic signed [49:0] s;
		e = {{18{v[VEL_W-1]}}, v};
		qe = {2'b00, q};
		s = neg ? e - qe : e + qe;
		if (s > VEL_MAX50) return 32'sh7FFFFFFF;
		if (s < VEL_MIN50) return 32'sh80000000;
		return s[VEL_W-1:0];
	endfunction

	logic [MASS_W-1:0] mass_q;
	logic signed [VEL_W-1:0] vx_q;
	logic signed [VEL_W-1:0] vy_q;
	logic stop_q;
	logic signed [MAG_W-1:0] mag_q;
	logic signed [ANG_W-1:0] ang_q;
	logic rneg_q;
	logic flip_q;
	logic vec_q;
	logic [FOLD_W-1:0] zm_q;
	logic signed [CX_W-1:0] cx_q;
	logic signed [CX_W-1:0] cy_q;
	logic signed [CZ_W-1:0] cz_q;
	logic signed [TRIG_W-1:0] sin_q;
	logic signed [TRIG_W-1:0] cos_q;
	logic [63:0] prod_q;
	logic [63:0] acc_q;
	logic [23:0] wlo_q;
	logic [SPEED_W-1:0] speed_q;
	logic signed [HEAD_W-1:0] heading_q;
	logic signed [DRIVE_W-1:0] drive_q [3];
	logic [OUT_DATA_W-1:0] out_q;

	logic [MASS_W-1:0] mass_eff;
	fold_t fold_in;
	fold_t fold_w;
	logic [FOLD_W-1:0] zm;
	logic signed [FOLD_W-1:0] wdeg;
	logic signed [FOLD_W-1:0] woff;
	logic div_start;
	logic [DIV_NUM_W-1:0] div_num;
	logic [DIV_DEN_W-1:0] div_den;
	logic [DIV_NUM_W-1:0] div_quo;
	logic div_done;
	logic signed [CZ_W-1:0] zq;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [MAG_W-1:0] am;
	logic [TRIG_W-1:0] sin_abs;
	logic [TRIG_W-1:0] cos_abs;
	logic signed [CX_W-1:0] cy_abs;
	logic signed [CX_W-1:0] sh_x;
	logic signed [CX_W-1:0] sh_y;
	logic signed [CZ_W-1:0] at;
	logic dir;
	logic signed [CX_W-1:0] x0;
	logic signed [CX_W-1:0] y0;
	logic vel_zero;
	logic [CX_W-1:0] xpos;
	logic [63:0] spd_sum;
	logic [CZ_W-1:0] cz_abs;
	logic [CZ_W-1:0] hsum;
	logic [9:0] hm10;
	logic [8:0] hm9;
	logic [63:0] wa;
	logic [63:0] wr;
	logic [41:0] wq;
	logic [DRIVE_W-1:0] wc9;

	assign mass_eff = (mass_q == '0) ? MASS_W'(1) : mass_q;
	assign fold_in = fold_angle({{(FOLD_W - ANG_W){ang_q[ANG_W-1]}}, ang_q}, FULL_HD);
	assign zm = fold_in.r[FOLD_W-1] ? FOLD_W'(-fold_in.r) : fold_in.r;
	assign zq = prod_q[RECIP_SH +: CZ_W];

	always_comb begin
		case (cmd.wheel)
			2'd0: woff = 19'sd180;
			2'd1: woff = 19'sd60;
			default: woff = -19'sd60;
		endcase
	end
	assign wdeg = {{(FOLD_W - HEAD_W){heading_q[HEAD_W-1]}}, heading_q} + woff;
	assign fold_w = fold_angle(wdeg, FULL_DEG);

	assign div_start = (cmd.op == DP_DIVX) || (cmd.op == DP_DIVY);
	assign div_num = prod_q[DIV_NUM_W-1:0] + DIV_NUM_W'({mass_eff, 13'b0});
	assign div_den = {mass_eff, 14'b0};

	owi_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.num(div_num),
		.den(div_den),
		.quo(div_quo),
		.done(div_done)
	);

	assign am = mag_q[MAG_W-1] ? MAG_W'(-mag_q) : mag_q;
	assign sin_abs = sin_q[TRIG_W-1] ? TRIG_W'(-sin_q) : sin_q;
	assign cos_abs = cos_q[TRIG_W-1] ? TRIG_W'(-cos_q) : cos_q;
	assign cy_abs = cy_q[CX_W-1] ? -cy_q : cy_q;
	assign xpos = cx_q[CX_W-1] ? '0 : cx_q;

	always_comb begin
		case (cmd.op)
			DP_ZDIV: begin
				mul_a = {zm_q[15:0], 16'b0} + 32'd50;
				mul_b = RECIP_100;
			end
			DP_MULX: begin
				mul_a = 32'(am);
				mul_b = sin_abs;
			end
			DP_MULY: begin
				mul_a = 32'(am);
				mul_b = cos_abs;
			end
			DP_SPD1: begin
				mul_a = 32'(xpos[CX_W-1:19]);
				mul_b = GAIN_Q24;
			end
			DP_SPD2: begin
				mul_a = 32'(xpos[18:0]);
				mul_b = GAIN_Q24;
			end
			DP_WM1: begin
				mul_a = speed_q;
				mul_b = 32'(PWM_FULL_SCALE);
			end
			DP_WM2: begin
				mul_a = 32'(prod_q[SC_W-1:24]);
				mul_b = cy_abs[31:0];
			end
			DP_WM3: begin
				mul_a = 32'(wlo_q);
				mul_b = cy_abs[31:0];
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign sh_x = cx_q >>> cmd.step;
	assign sh_y = cy_q >>> cmd.step;
	assign at = atan_q16(cmd.step);
	assign dir = vec_q ? cy_q[CX_W-1] : !cz_q[CZ_W-1];

	assign x0 = {{4{vy_q[VEL_W-1]}}, vy_q, 4'b0};
	assign y0 = {{4{vx_q[VEL_W-1]}}, vx_q, 4'b0};
	assign vel_zero = (vx_q == '0) && (vy_q == '0);

	assign spd_sum = acc_q + prod_q + (64'd1 << 27);
	assign cz_abs = cz_q[CZ_W-1] ? CZ_W'(-cz_q) : cz_q;
	assign hsum = cz_abs + CZ_W'(128);
	assign hm10 = hsum[CZ_W-1:16];
	assign hm9 = (hm10 > 10'd180) ? 9'd180 : hm10[8:0];

	assign wa = acc_q + {24'b0, prod_q[63:24]};
	assign wr = wa + (64'd1 << 21);
	assign wq = wr[63:22];
	assign wc9 = {1'b0, (wq > 42'(DRIVE_LIMIT)) ? DRIVE_LIMIT : wq[7:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mass_q <= MASS_RESET;
			vx_q <= '0;
			vy_q <= '0;
		end else begin
			if (cfg_wr_en) mass_q <= cfg_wr_data;
			if (cmd.op == DP_UPDX) vx_q <= sat_add(vx_q, div_quo, mag_q[MAG_W-1] ^ sin_q[TRIG_W-1]);
			if (cmd.op == DP_UPDY) vy_q <= sat_add(vy_q, div_quo, mag_q[MAG_W-1] ^ cos_q[TRIG_W-1]);
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		zm_q <= zm;
		case (cmd.op)
			DP_LOAD: begin
				stop_q <= in_op == OP_STOP;
				mag_q <= in_data[MAG_W-1:0];
				ang_q <= in_data[MAG_W +: ANG_W];
			end
			DP_ZDIV: begin
				rneg_q <= fold_in.r[FOLD_W-1];
				flip_q <= fold_in.flip;
			end
			DP_ROT_INIT: begin
				vec_q <= 1'b0;
				cx_q <= GAIN_Q30;
				cy_q <= '0;
				cz_q <= rneg_q ? -zq : zq;
			end
			DP_ITER: begin
				if (dir) begin
					cx_q <= cx_q - sh_y;
					cy_q <= cy_q + sh_x;
					cz_q <= cz_q - at;
				end else begin
					cx_q <= cx_q + sh_y;
					cy_q <= cy_q - sh_x;
					cz_q <= cz_q + at;
				end
			end
			DP_TRIG: begin
				sin_q <= cy_q[TRIG_W-1:0];
				cos_q <= flip_q ? TRIG_W'(-cx_q) : cx_q[TRIG_W-1:0];
			end
			DP_VPREP: begin
				vec_q <= 1'b1;
				if (vel_zero) begin
					speed_q <= '0;
					heading_q <= '0;
				end else if (x0 < 0) begin
					if (y0 >= 0) begin
						cx_q <= y0;
						cy_q <= -x0;
						cz_q <= Z90;
					end else begin
						cx_q <= -y0;
						cy_q <= x0;
						cz_q <= -Z90;
					end
				end else begin
					cx_q <= x0;
					cy_q <= y0;
					cz_q <= '0;
				end
			end
			DP_SPD2: acc_q <= prod_q << 19;
			DP_SPD3: begin
				speed_q <= (spd_sum[63:60] != 4'b0) ? '1 : spd_sum[59:28];
				heading_q <= cz_q[CZ_W-1] ? HEAD_W'(-hm9) : hm9;
			end
			DP_WSET: begin
				vec_q <= 1'b0;
				cx_q <= GAIN_Q30;
				cy_q <= '0;
				cz_q <= {fold_w.r[9:0], 16'b0};
			end
			DP_WM2: wlo_q <= prod_q[23:0];
			DP_WM3: acc_q <= prod_q;
			DP_WM4: drive_q[cmd.wheel] <= cy_q[CX_W-1] ? DRIVE_W'(-wc9) : wc9;
			DP_OUT: begin
				out_q <= stop_q ? '0 :
					{4'b0, speed_q, heading_q, drive_q[2], drive_q[1], drive_q[0]};
			end
			default: ;
		endcase
	end

	assign stat.stop = stop_q;
	assign stat.vel_zero = vel_zero;
	assign stat.div_done = div_done;
	assign out_data = out_q;

endmodule

/* rtl/core/omni_wheel_impulse_drive.sv */
// Top level of the three-wheel omni drive that turns impulses into wheel drives.
// Items arrive on the s_ stream: s_tuser is the operation (apply an impulse or
// stop), s_tdata carries magnitude and angle. Each item gives exactly one beat
// on the m_ stream with the three signed wheel drives, the heading in whole
// degrees and the speed. The robot mass is written through cfg_wr_en and
// cfg_wr_data only while the block is idle; the user must keep to that, the
// block itself does not enforce it.
// A stop item leaves the velocity alone and goes straight to its result beat.
// An apply item takes two divisions by the mass in the one-bit-per-cycle
// divider and five 18-step CORDIC passes on the one shared iteration stage
// (four passes when the velocity ends up zero).
// One item is worked on at a time; s_tready is high only while the block waits
// for an item. The result sits in an output register; when the receiver stalls
// the next item may still be accepted and computed, and it waits for the output
// register to empty before it is written there.
// Reset clears the velocity to zero, sets the mass to 512 and empties the
// output register.
module omni_wheel_impulse_drive import owi_pkg::*; #(
	parameter int unsigned PWM_FULL_SCALE = PWM_FULL_SCALE_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	// magnitude [15:0], angle [32:16], zero padding above
	input logic [IN_DATA_W-1:0] s_tdata,
	// operation
	input logic s_tuser,
	output logic m_tvalid,
	input logic m_tready,
	// wheel_a_drive [8:0], wheel_b_drive [17:9], wheel_c_drive [26:18],
	// heading_degrees [35:27], speed_out [67:36], zero padding above
	output logic [OUT_DATA_W-1:0] m_tdata,
	input logic cfg_wr_en,
	input logic [MASS_W-1:0] cfg_wr_data
);

	dp_cmd_t cmd;
	dp_stat_t stat;

	owi_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.stat(stat),
		.cmd(cmd)
	);

	owi_dpath #(
		.PWM_FULL_SCALE(PWM_FULL_SCALE)
	) u_dpath (
		.clk(clk),
		.arst_n(arst_n),
		.in_data(s_tdata),
		.in_op(s_tuser),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.cmd(cmd),
		.stat(stat),
		.out_data(m_tdata)
	);

	a_load_on_beat: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == DP_LOAD |-> s_tvalid && s_tready)
		else $error("input latched without an input beat");

	a_div_done_used: assert property (@(posedge clk) disable iff (!arst_n)
		stat.div_done |-> (cmd.op == DP_UPDX || cmd.op == DP_UPDY))
		else $error("division result not consumed");

	a_out_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == DP_OUT |=> m_tvalid)
		else $error("result written but not presented");

endmodule

/* test/omni_wheel_impulse_drive_test.sv */
// Self-checking testbench of the omni wheel impulse drive: directed table, then random impulses.
`timescale 1ns / 1ps

module omni_wheel_impulse_drive_test import owi_pkg::*;;

	typedef struct packed {
		logic signed [DRIVE_W-1:0] wheel_a;
		logic signed [DRIVE_W-1:0] wheel_b;
		logic signed [DRIVE_W-1:0] wheel_c;
		logic signed [HEAD_W-1:0] heading;
		logic [SPEED_W-1:0] speed;
	} drive_beat_t;

	typedef struct {
		logic op;
		logic signed [MAG_W-1:0] mag;
		logic signed [ANG_W-1:0] ang;
		bit all_zero;
	} impulse_row_t;

	localparam longint ATAN_DEG_Q16[CORDIC_STEPS] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335, 14668,
		7334, 3667, 1833, 917, 458, 229, 115, 57, 29
	};
	localparam longint VEL_HI = 64'sd2147483647;
	localparam longint VEL_LO = -64'sd2147483648;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata;
	logic s_tuser;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic cfg_wr_en;
	logic [MASS_W-1:0] cfg_wr_data;

	drive_beat_t pending_drives[$];
	longint vel_x;
	longint vel_y;
	longint mass_q48;
	int mismatches;
	int send_idle;
	int rcv_idle;
	bit hold_req;
	bit hold_seen = 1'b0;
	int hold_left = 0;

	omni_wheel_impulse_drive u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic void rotate_sin_cos(input longint hd, output longint s, output longint c);
		longint r;
		longint m;
		longint x;
		longint y;
		longint z;
		longint dx;
		longint dy;
		bit flip;
		r = hd % 36000;
		if (r < 0) r += 36000;
		if (r >= 18000) r -= 36000;
		flip = 1'b0;
		if (r > 9000) begin
			r = 18000 - r;
			flip = 1'b1;
		end else if (r < -9000) begin
			r = -18000 - r;
			flip = 1'b1;
		end
		m = (r < 0) ? -r : r;
		z = (m * 65536 + 50) / 100;
		if (r < 0) z = -z;
		x = 652032874;
		y = 0;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx;
				y += dy;
				z -= ATAN_DEG_Q16[i];
			end else begin
				x += dx;
				y -= dy;
				z += ATAN_DEG_Q16[i];
			end
		end
		c = flip ? -x : x;
		s = y;
	endfunction

	function automatic longint velocity_step(input longint mag, input longint trig,
			input longint mass);
		longint am;
		longint at;
		longint den;
		longint q;
		am = (mag < 0) ? -mag : mag;
		at = (trig < 0) ? -trig : trig;
		den = mass << 14;
		q = (am * at + (den >> 1)) / den;
		return ((mag < 0) != (trig < 0)) ? -q : q;
	endfunction

	function automatic longint clamp_velocity(input longint v);
		if (v > VEL_HI) return VEL_HI;
		if (v < VEL_LO) return VEL_LO;
		return v;
	endfunction

	function automatic logic signed [DRIVE_W-1:0] pwm_for(input longint speed, input longint deg);
		longint s;
		longint c;
		longint mag;
		longint prod;
		longint r;
		rotate_sin_cos(deg * 100, s, c);
		mag = (s < 0) ? -s : s;
		prod = speed * 255;
		r = ((prod >> 24) * mag + (((prod & 64'hFFFFFF) * mag) >> 24) + (64'd1 << 21)) >> 22;
		if (r > 255) r = 255;
		return DRIVE_W'((s < 0) ? -r : r);
	endfunction

	function automatic drive_beat_t predict_drives(input logic op, input longint mag,
			input longint ang);
		drive_beat_t b;
		longint s;
		longint c;
		longint m;
		longint bx;
		longint by;
		longint z;
		longint t;
		longint dx;
		longint dy;
		longint hm;
		longint heading;
		longint speed;
		b = '0;
		if (op == OP_STOP) return b;
		m = (mass_q48 == 0) ? 1 : mass_q48;
		rotate_sin_cos(ang, s, c);
		vel_x = clamp_velocity(vel_x + velocity_step(mag, s, m));
		vel_y = clamp_velocity(vel_y + velocity_step(mag, c, m));
		heading = 0;
		speed = 0;
		if (vel_x != 0 || vel_y != 0) begin
			bx = vel_y * 16;
			by = vel_x * 16;
			z = 0;
			if (bx < 0) begin
				t = bx;
				if (by >= 0) begin
					bx = by;
					by = -t;
					z = 90 * 65536;
				end else begin
					bx = -by;
					by = t;
					z = -90 * 65536;
				end
			end
			for (int i = 0; i < CORDIC_STEPS; i++) begin
				dx = by >>> i;
				dy = bx >>> i;
				if (by < 0) begin
					bx -= dx;
					by += dy;
					z -= ATAN_DEG_Q16[i];
				end else begin
					bx += dx;
					by -= dy;
					z += ATAN_DEG_Q16[i];
				end
			end
			if (bx < 0) bx = 0;
			speed = (bx * 10188014 + (64'd1 << 27)) >> 28;
			if (speed > 64'hFFFFFFFF) speed = 64'hFFFFFFFF;
			hm = (z < 0) ? -z : z;
			hm = (hm + 128) >> 16;
			if (hm > 180) hm = 180;
			heading = (z < 0) ? -hm : hm;
		end
		b.wheel_a = pwm_for(speed, heading + 180);
		b.wheel_b = pwm_for(speed, heading + 60);
		b.wheel_c = pwm_for(speed, heading - 60);
		b.heading = HEAD_W'(heading);
		b.speed = SPEED_W'(speed);
		return b;
	endfunction

	task automatic send_impulse(input logic op, input logic signed [MAG_W-1:0] mag,
			input logic signed [ANG_W-1:0] ang, input bit all_zero);
		drive_beat_t b;
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {{(IN_DATA_W-MAG_W-ANG_W){1'b0}}, ang, mag};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		b = predict_drives(op, mag, ang);
		if (all_zero) b = '0;
		pending_drives.push_back(b);
		@(negedge clk);
	endtask

	task automatic set_mass(input logic [MASS_W-1:0] value);
		s_tvalid <= 1'b0;
		while (pending_drives.size() != 0) @(negedge clk);
		repeat (300) @(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		mass_q48 = value;
	endtask

	always @(negedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= 1500;
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rcv_idle);
		end
	end

	always @(posedge clk) begin
		drive_beat_t got;
		drive_beat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.wheel_a = m_tdata[8:0];
			got.wheel_b = m_tdata[17:9];
			got.wheel_c = m_tdata[26:18];
			got.heading = m_tdata[35:27];
			got.speed = m_tdata[67:36];
			if (pending_drives.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected beat: %p", got);
			end else begin
				want = pending_drives.pop_front();
				if (got.wheel_a !== want.wheel_a || got.wheel_b !== want.wheel_b ||
						got.wheel_c !== want.wheel_c || got.heading !== want.heading ||
						got.speed !== want.speed) begin
					mismatches++;
					if (mismatches <= 10)
						$display("drive mismatch: expected a=%0d b=%0d c=%0d hdg=%0d spd=%0h, got a=%0d b=%0d c=%0d hdg=%0d spd=%0h",
							want.wheel_a, want.wheel_b, want.wheel_c, want.heading, want.speed,
							got.wheel_a, got.wheel_b, got.wheel_c, got.heading, got.speed);
				end
			end
		end
	end

	initial begin
		#20ms;
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		impulse_row_t rows[$];
		int masses[4];
		logic op;
		logic signed [MAG_W-1:0] mag;
		logic signed [ANG_W-1:0] ang;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = OP_APPLY;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		hold_req = 1'b0;
		mismatches = 0;
		send_idle = 13;
		rcv_idle = 53;
		vel_x = 0;
		vel_y = 0;
		mass_q48 = MASS_RESET;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		rows = '{
			'{OP_STOP, 16'sh7FFF, 17'sh0FFFF, 1'b1},
			'{OP_APPLY, 16'sd0, 17'sd0, 1'b1},
			'{OP_APPLY, 16'sd0, 17'sd9000, 1'b1},
			'{OP_APPLY, 16'sd256, 17'sd0, 1'b0},
			'{OP_APPLY, 16'sd256, 17'sd9000, 1'b0},
			'{OP_APPLY, 16'sd256, -17'sd9000, 1'b0},
			'{OP_APPLY, 16'sd512, 17'sd18000, 1'b0},
			'{OP_APPLY, 16'sd100, 17'sd17999, 1'b0},
			'{OP_APPLY, 16'sd100, -17'sd18000, 1'b0},
			'{OP_APPLY, 16'sh7FFF, 17'sd36000, 1'b0},
			'{OP_APPLY, -16'sh8000, -17'sd36000, 1'b0},
			'{OP_APPLY, 16'sd3000, 17'sh0FFFF, 1'b0},
			'{OP_APPLY, -16'sd3000, -17'sh10000, 1'b0},
			'{OP_STOP, -16'sh8000, -17'sh10000, 1'b1},
			'{OP_APPLY, 16'sd1, 17'sd4500, 1'b0},
			'{OP_APPLY, -16'sd1, 17'sd13500, 1'b0},
			'{OP_APPLY, 16'sh7FFF, 17'sd12345, 1'b0},
			'{OP_APPLY, 16'sh7FFF, 17'sd12345, 1'b0},
			'{OP_APPLY, -16'sh8000, -17'sd27000, 1'b0}
		};
		foreach (rows[i]) send_impulse(rows[i].op, rows[i].mag, rows[i].ang, rows[i].all_zero);

		masses = '{1, 4095, 0, 0};
		masses[3] = $urandom_range(1, 4095);
		for (int p = 0; p < 4; p++) begin
			set_mass(MASS_W'(masses[p]));
			send_idle = (p == 0) ? 13 : (p == 1) ? 53 : 0;
			rcv_idle = (p == 0) ? 53 : (p == 1) ? 13 : 0;
			if (p == 2) begin
				@(posedge clk);
				hold_req = ~hold_req;
				@(negedge clk);
			end
			for (int n = 0; n < 120; n++) begin
				op = ($urandom_range(9) == 0) ? OP_STOP : OP_APPLY;
				case ($urandom_range(3))
					0: mag = MAG_W'($urandom_range(0, 65535));
					1: mag = MAG_W'($urandom_range(0, 1023) - 512);
					default: mag = MAG_W'($urandom_range(0, 16383) - 8192);
				endcase
				if ($urandom_range(7) == 0) ang = ANG_W'($urandom_range(0, 131071));
				else ang = ANG_W'($urandom_range(0, 72000) - 36000);
				send_impulse(op, mag, ang, 1'b0);
			end
			// Saturating burst on the lightest mass drives the velocity to its rails.
			if (p == 0)
				for (int n = 0; n < 6; n++) send_impulse(OP_APPLY, 16'sh7FFF, 17'sd4500, 1'b0);
		end

		s_tvalid <= 1'b0;
		while (pending_drives.size() != 0) @(negedge clk);
		repeat (400) @(negedge clk);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
